// ===== rtl/core/c32dt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c32dt_pkg
// shared constants and the byte reduction function for the crc-32 core
// ----------------------------------------------------------------------------
package c32dt_pkg;

    localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam int          TOP_SHIFT  = 24;
    localparam int          BYTE_SHIFT = 8;

    typedef logic [7:0]  t_byte;
    typedef logic [31:0] t_crc;

    // output stage handshake towards the core
    typedef struct packed {
        logic can_load;
    } t_out_ctrl;

    // reduction of one top byte, msb first, eight polynomial steps
    function automatic t_crc f_reduce_top(input t_byte top);
        t_crc v;
        v = t_crc'(top) << TOP_SHIFT;
        for (int k = 0; k < 8; k++) begin
            if (v[31]) begin
                v = (v << 1) ^ CRC_POLY;
            end else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/c32dt_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c32dt_step
// one augmented table step: reduce the top byte and shift in the new byte
// ----------------------------------------------------------------------------
module c32dt_step (
    input  wire c32dt_pkg::t_crc  i_remainder,
    input  wire c32dt_pkg::t_byte i_data,
    input  wire logic             i_first,
    output c32dt_pkg::t_crc       o_remainder
);
    import c32dt_pkg::*;

    t_crc base;

    assign base        = i_first ? '0 : i_remainder;
    assign o_remainder = f_reduce_top(base[31:TOP_SHIFT])
                         ^ ((base << BYTE_SHIFT) | t_crc'(i_data));

endmodule
`default_nettype wire

// ===== rtl/core/c32dt_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c32dt_out_reg
// result register on the master side, loaded when a last item completes
// ----------------------------------------------------------------------------
module c32dt_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire c32dt_pkg::t_crc     i_checksum,
    input  wire logic                i_load,
    output c32dt_pkg::t_out_ctrl     o_ctrl,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output c32dt_pkg::t_crc          o_m_tdata
);
    import c32dt_pkg::*;

    logic r_valid;
    t_crc r_data;

    assign o_ctrl.can_load = !r_valid || i_m_tready;
    assign o_m_tvalid      = r_valid;
    assign o_m_tdata       = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ctrl.can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ctrl.can_load && i_load) begin
            r_data <= i_checksum;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/crc32_direct_table_stream_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_direct_table_stream_core
// crc-32 (poly 04c11db7, msb first, augmented, init zero) over a byte stream
// ----------------------------------------------------------------------------
// path: an accepted last item passes the input register, then the output register, to o_m_tvalid
// throughput: one item per cycle; the remainder update is a single table step
// a checksum waiting in the output register stalls only a following last item and the items behind it
// reset: synchronous, active low; clears the valid flags and the remainder
// ----------------------------------------------------------------------------
module crc32_direct_table_stream_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire c32dt_pkg::t_byte i_s_tdata,  // [7:0] data_byte
    input  wire logic            i_s_tuser,  // [0] first
    input  wire logic            i_s_tlast,  // last
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output c32dt_pkg::t_crc      o_m_tdata   // [31:0] checksum
);
    import c32dt_pkg::*;

    logic      r_in_valid;
    t_byte     r_in_data;
    logic      r_in_first;
    logic      r_in_last;
    t_crc      r_remainder;
    t_crc      n_remainder;
    logic      advance;
    t_out_ctrl out_ctrl;

    assign advance    = r_in_valid && (!r_in_last || out_ctrl.can_load);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data  <= i_s_tdata;
            r_in_first <= i_s_tuser;
            r_in_last  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remainder <= '0;
        end else if (advance) begin
            r_remainder <= n_remainder;
        end
    end

    c32dt_step u_step (
        .i_remainder (r_remainder),
        .i_data      (r_in_data),
        .i_first     (r_in_first),
        .o_remainder (n_remainder)
    );

    c32dt_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_checksum (~n_remainder),
        .i_load     (advance && r_in_last),
        .o_ctrl     (out_ctrl),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/core/c32dt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c32dt_checker
// port-level checks on the crc-32 core, bound to the top level
// ----------------------------------------------------------------------------
module c32dt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata
);

    // a result waits until taken
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // reset leaves no result behind
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // an empty output stage never blocks the slave side
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready) |-> o_s_tready)
        else $error("input stalled while output drains");

endmodule

bind crc32_direct_table_stream_core c32dt_checker u_c32dt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

// ===== bench/tb_crc32_direct_table_stream_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc32_direct_table_stream_core
// checks crc-32 checksums of byte messages against a bit-serial predictor;
// directed edge cases, then random messages under changing back-pressure
// ----------------------------------------------------------------------------
module tb_crc32_direct_table_stream_core;

    import c32dt_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    class crc_scoreboard;
        t_crc running;
        t_crc sums_due[$];
        int   errors;

        function new();
            running = '0;
            errors  = 0;
        endfunction

        // shift the byte in bit by bit, msb first, reducing each popped bit
        function t_crc fold_byte(input t_crc r, input t_byte d);
            logic popped;
            for (int i = 7; i >= 0; i--) begin
                popped = r[31];
                r = {r[30:0], d[i]};
                if (popped) begin
                    r = r ^ CRC_POLY;
                end
            end
            return r;
        endfunction

        function void note_item(input t_byte d, input logic first, input logic last);
            running = fold_byte(first ? '0 : running, d);
            if (last) begin
                sums_due.push_back(~running);
            end
        endfunction

        function void check_sum(input t_crc got);
            t_crc want;
            if (sums_due.size() == 0) begin
                $error("checksum: expected none, got %08h", got);
                errors++;
            end else begin
                want = sums_due.pop_front();
                if (got !== want) begin
                    $error("checksum: expected %08h, got %08h", want, got);
                    errors++;
                end
            end
        endfunction

        function int due();
            return sums_due.size();
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_s_tvalid = 1'b0;
    logic  o_s_tready;
    t_byte i_s_tdata = '0;    // [7:0] data_byte
    logic  i_s_tuser = 1'b0;  // [0] first
    logic  i_s_tlast = 1'b0;  // last
    logic  o_m_tvalid;
    logic  i_m_tready = 1'b0;
    t_crc  o_m_tdata;         // [31:0] checksum

    int send_idle_pct = 23;
    int recv_stall_pct = 78;
    int quiet_cycles = 0;

    crc_scoreboard board = new();

    crc32_direct_table_stream_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // accepted items on both sides, receiver stalls and the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            board.note_item(i_s_tdata, i_s_tuser, i_s_tlast);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_sum(o_m_tdata);
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_crc32_direct_table_stream_core NOT OK");
            $finish;
        end
    end

    task automatic push_byte(input t_byte d, input logic first, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= t_byte'($urandom);
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= first;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_message(input int len, input bit tidy);
        for (int n = 0; n < len; n++) begin
            if (tidy) begin
                push_byte(t_byte'($urandom_range(255)), n == 0, n == len - 1);
            end else begin
                push_byte(t_byte'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int sent;
        int len;
        sent = 0;
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
        while (sent < count) begin
            if ($urandom_range(3) == 0) begin
                len = $urandom_range(2, 1);
            end else if ($urandom_range(19) == 0) begin
                len = $urandom_range(40, 13);
            end else begin
                len = $urandom_range(12, 2);
            end
            // mostly framed messages, some with scrambled first and last flags
            send_message(len, $urandom_range(9) != 0);
            sent += len;
        end
    endtask

    initial begin
        string digits;
        digits = "123456789";
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no first flag straight after reset
        push_byte(8'h31, 1'b0, 1'b0);
        push_byte(8'h32, 1'b0, 1'b1);
        // one-byte messages at the byte extremes and alternating bit patterns
        push_byte(8'h00, 1'b1, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b1);
        push_byte(8'h80, 1'b1, 1'b1);
        push_byte(8'h01, 1'b1, 1'b1);
        push_byte(8'h55, 1'b1, 1'b1);
        push_byte(8'hAA, 1'b1, 1'b1);
        // nine-byte check string
        for (int n = 0; n < 9; n++) begin
            push_byte(digits[n], n == 0, n == 8);
        end
        // carrying on from the remainder after a checksum
        push_byte(8'h7E, 1'b0, 1'b1);
        push_byte(8'hC3, 1'b0, 1'b0);
        push_byte(8'h3C, 1'b0, 1'b1);

        run_phase(23, 78, 210);
        run_phase(78, 23, 210);
        run_phase(0, 0, 210);
        i_s_tvalid <= 1'b0;

        while (board.due() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.due() == 0) begin
            $display("tb_crc32_direct_table_stream_core OK");
        end else begin
            $display("tb_crc32_direct_table_stream_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== crc32_direct_table_stream_core.f =====
rtl/core/c32dt_pkg.sv
rtl/core/c32dt_step.sv
rtl/core/c32dt_out_reg.sv
rtl/core/crc32_direct_table_stream_core.sv
rtl/core/c32dt_checker.sv
bench/tb_crc32_direct_table_stream_core.sv
